// ===== rtl/core/rtfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Radar target frame parser package
// Sizes, command, status and register codes shared by the parser.
// ----------------------------------------------------------------------------
package rtfp_pkg;

   localparam int unsigned FRAME_BYTES = 64;
   localparam int unsigned MAX_TARGETS = 8;
   localparam int unsigned HDR_BYTES   = 5;
   localparam int unsigned TGT_BYTES   = 4;

   localparam int unsigned POS_W     = $clog2(FRAME_BYTES);
   localparam int unsigned MAX_PLEN  = FRAME_BYTES - 3;
   localparam int unsigned TGT_START = HDR_BYTES + 2;
   localparam int unsigned TGT_END   = TGT_START + TGT_BYTES * MAX_TARGETS;
   localparam int unsigned TGT_IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
   localparam int unsigned TGT_OFF_W = TGT_IDX_W + 2;
   localparam int unsigned CNT_W     = $clog2(MAX_TARGETS + 1);
   localparam int unsigned TGT_W     = 8 * TGT_BYTES;

   localparam logic [7:0] ERR_LIMIT_RST = 8'd20;

   typedef enum logic [1:0] {
      CMD_FEED  = 2'd0,
      CMD_ABORT = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_CHECKSUM = 2'd1,
      ST_TYPE     = 2'd2,
      ST_LENGTH   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_HEADER = 2'd0,
      REG_TYPE   = 2'd1,
      REG_LIMIT  = 2'd2,
      REG_SPARE  = 2'd3
   } reg_index_type;

endpackage

// ===== rtl/core/radar_target_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Radar target frame parser
// Finds framed radar packets in a byte stream, checks them and emits one
// record per target, an empty record or an error record per frame.
// ----------------------------------------------------------------------------
// Each transaction on the request channel carries one byte or command and
// is taken while the result register is free and no targets are pending.
// The byte that ends a frame yields its record at once for an error or an
// empty frame; for a good frame with N targets the parser then stops taking
// requests until all N are sent, each read from the target store (S_FETCH)
// and loaded into the result register (S_SEND, held while it is full).
// Statistics in every record are those after the frame that produced it.
module radar_target_frame_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [3:0]           rsp_object_count,
   output logic [15:0]          rsp_reserved_word,
   output logic                 rsp_target_valid,
   output logic [7:0]           rsp_distance,
   output logic signed [7:0]    rsp_angle,
   output logic signed [7:0]    rsp_speed,
   output logic [7:0]           rsp_target_id,
   output logic                 rsp_last,
   output logic [31:0]          rsp_frames_total,
   output logic [31:0]          rsp_frames_bad,
   output logic                 rsp_resync_request,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata
);
   import rtfp_pkg::*;

   typedef enum logic [1:0] {P_HUNT, P_LEN, P_DATA, P_SPARE} phase_type;
   typedef enum logic [1:0] {S_RUN, S_FETCH, S_SEND} state_type;

   logic [7:0]           hdr_ff, type_code_ff, limit_ff;
   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic [POS_W-1:0]     pos_ff, pos_in, len_ff, len_in;
   logic [7:0]           sum_ff, sum_in;
   logic [7:0]           type_ff, type_in, cnt_lo_ff, cnt_lo_in, cnt_hi_ff, cnt_hi_in;
   logic [7:0]           resv_lo_ff, resv_lo_in, resv_hi_ff, resv_hi_in;
   logic [31:0]          seen_ff, seen_in, bad_ff, bad_in;
   logic [7:0]           run_ff, run_in;
   logic [TGT_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   logic [3:0]           obj_ff, obj_in;
   logic [15:0]          resv_ff, resv_in;
   logic                 tvalid_ff, tvalid_in;
   logic [TGT_W-1:0]     tgt_ff, tgt_in;
   logic                 last_ff, last_in;
   logic [31:0]          total_ff, total_in, fbad_ff, fbad_in;
   logic                 resync_ff, resync_in;
   logic                 load;

   logic [TGT_W-1:0]     mem [MAX_TARGETS];
   logic [TGT_W-1:0]     mem_q_ff;
   logic                 mem_we;
   logic [TGT_OFF_W-1:0] tgt_off;

   logic                 out_free;
   logic [7:0]           b;
   logic [7:0]           type_b;
   logic [15:0]          cnt16;
   logic [CNT_W-1:0]     clamp;
   logic [31:0]          seen_n, bad_n;
   logic [7:0]           run_n, lim;
   status_type           status_c;
   logic                 is_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_RUN) && out_free;
   assign csr_ready = 1'b1;
   assign b         = req_rx_byte;
   assign tgt_off   = TGT_OFF_W'(32'(pos_ff) - TGT_START);
   assign cnt16     = {cnt_hi_ff, cnt_lo_ff};
   assign clamp     = (32'(cnt16) > MAX_TARGETS) ? CNT_W'(MAX_TARGETS) : CNT_W'(cnt16);
   assign type_b    = (32'(pos_ff) == 2) ? b : type_ff;
   assign seen_n    = seen_ff + 32'd1;
   assign bad_n     = bad_ff + 32'd1;
   assign run_n     = run_ff + 8'd1;
   assign lim       = (limit_ff == 8'd0) ? 8'd1 : limit_ff;
   assign is_last   = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      if (sum_ff != b) begin
         status_c = ST_CHECKSUM;
      end else if (type_b != type_code_ff) begin
         status_c = ST_TYPE;
      end else if (32'(len_ff) < HDR_BYTES ||
                   32'(len_ff) != HDR_BYTES + TGT_BYTES * 32'(clamp)) begin
         status_c = ST_LENGTH;
      end else begin
         status_c = ST_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      type_in      = type_ff;
      cnt_lo_in    = cnt_lo_ff;
      cnt_hi_in    = cnt_hi_ff;
      resv_lo_in   = resv_lo_ff;
      resv_hi_in   = resv_hi_ff;
      seen_in      = seen_ff;
      bad_in       = bad_ff;
      run_in       = run_ff;
      rd_idx_in    = rd_idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load         = 1'b0;
      status_in    = ST_OK;
      obj_in       = 4'd0;
      resv_in      = 16'd0;
      tvalid_in    = 1'b0;
      tgt_in       = '0;
      last_in      = 1'b1;
      total_in     = seen_ff;
      fbad_in      = bad_ff;
      resync_in    = 1'b0;
      mem_we       = 1'b0;

      unique case (state_ff)
         S_RUN: begin
            if (req_valid && req_ready) begin
               unique case (req_cmd)
                  CMD_ABORT: phase_in = P_HUNT;
                  CMD_CLEAR: begin
                     seen_in = 32'd0;
                     bad_in  = 32'd0;
                  end
                  CMD_FEED: begin
                     unique case (phase_ff)
                        P_HUNT: begin
                           if (b == hdr_ff) begin
                              sum_in   = b;
                              pos_in   = POS_W'(1);
                              phase_in = P_LEN;
                           end
                        end
                        P_LEN: begin
                           if (32'(b) > MAX_PLEN) begin
                              phase_in = P_HUNT;
                           end else begin
                              len_in   = POS_W'(b);
                              sum_in   = sum_ff + b;
                              pos_in   = POS_W'(2);
                              phase_in = P_DATA;
                           end
                        end
                        P_DATA: begin
                           unique case (32'(pos_ff))
                              2:       type_in    = b;
                              3:       cnt_lo_in  = b;
                              4:       cnt_hi_in  = b;
                              5:       resv_lo_in = b;
                              6:       resv_hi_in = b;
                              default: ;
                           endcase
                           mem_we = (32'(pos_ff) >= TGT_START) && (32'(pos_ff) < TGT_END);
                           if (pos_ff == len_ff + POS_W'(2)) begin
                              phase_in = P_HUNT;
                              seen_in  = seen_n;
                              if (status_c != ST_OK) begin
                                 bad_in       = bad_n;
                                 load         = 1'b1;
                                 rsp_valid_in = 1'b1;
                                 status_in    = status_c;
                                 total_in     = seen_n;
                                 fbad_in      = bad_n;
                                 if (run_n >= lim) begin
                                    run_in    = 8'd0;
                                    resync_in = 1'b1;
                                 end else begin
                                    run_in = run_n;
                                 end
                              end else begin
                                 run_in = 8'd0;
                                 if (clamp == '0) begin
                                    load         = 1'b1;
                                    rsp_valid_in = 1'b1;
                                    resv_in      = {resv_hi_ff, resv_lo_ff};
                                    total_in     = seen_n;
                                 end else begin
                                    count_in  = clamp;
                                    rd_idx_in = '0;
                                    state_in  = S_FETCH;
                                 end
                              end
                           end else begin
                              sum_in = sum_ff + b;
                              pos_in = pos_ff + POS_W'(1);
                           end
                        end
                        default: phase_in = P_HUNT;
                     endcase
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: state_in = S_SEND;
         S_SEND: begin
            if (out_free) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               obj_in       = 4'(count_ff);
               resv_in      = {resv_hi_ff, resv_lo_ff};
               tvalid_in    = 1'b1;
               tgt_in       = mem_q_ff;
               last_in      = is_last;
               if (is_last) begin
                  state_in = S_RUN;
               end else begin
                  rd_idx_in = rd_idx_ff + TGT_IDX_W'(1);
                  state_in  = S_FETCH;
               end
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tgt_off[TGT_OFF_W-1:2]][{tgt_off[1:0], 3'b000} +: 8] <= b;
      end
      mem_q_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= 8'd0;
         type_code_ff <= 8'd0;
         limit_ff     <= ERR_LIMIT_RST;
         state_ff     <= S_RUN;
         phase_ff     <= P_HUNT;
         pos_ff       <= '0;
         len_ff       <= '0;
         seen_ff      <= 32'd0;
         bad_ff       <= 32'd0;
         run_ff       <= 8'd0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_HEADER: hdr_ff       <= csr_wdata;
               REG_TYPE:   type_code_ff <= csr_wdata;
               REG_LIMIT:  limit_ff     <= csr_wdata;
               default:    ;
            endcase
         end
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         bad_ff       <= bad_in;
         run_ff       <= run_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff     <= sum_in;
      type_ff    <= type_in;
      cnt_lo_ff  <= cnt_lo_in;
      cnt_hi_ff  <= cnt_hi_in;
      resv_lo_ff <= resv_lo_in;
      resv_hi_ff <= resv_hi_in;
      if (load) begin
         status_ff <= status_in;
         obj_ff    <= obj_in;
         resv_ff   <= resv_in;
         tvalid_ff <= tvalid_in;
         tgt_ff    <= tgt_in;
         last_ff   <= last_in;
         total_ff  <= total_in;
         fbad_ff   <= fbad_in;
         resync_ff <= resync_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_object_count   = obj_ff;
   assign rsp_reserved_word  = resv_ff;
   assign rsp_target_valid   = tvalid_ff;
   assign rsp_distance       = tgt_ff[7:0];
   assign rsp_angle          = $signed(tgt_ff[15:8]);
   assign rsp_speed          = $signed(tgt_ff[23:16]);
   assign rsp_target_id      = tgt_ff[31:24];
   assign rsp_last           = last_ff;
   assign rsp_frames_total   = total_ff;
   assign rsp_frames_bad     = fbad_ff;
   assign rsp_resync_request = resync_ff;

   // An error transaction always closes its frame and carries no target.
   a_error_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && !rsp_target_valid)
      else $error("error record without last or with a target");

   a_resync_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_resync_request |-> rsp_status != ST_OK)
      else $error("resync request on a good record");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_RUN |-> CNT_W'(rd_idx_ff) < count_ff)
      else $error("target read index beyond the frame count");

   a_target_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_valid |-> rsp_object_count != 4'd0)
      else $error("target record with a zero object count");

endmodule
